// File: rtl/rmez_pkg.sv
// ----------------------------------------------------------------------------
// rmez_pkg
// Shared widths, constants, sideband types and helper functions for the
// rotation matrix to zyx euler angle pipeline.
// ----------------------------------------------------------------------------
package rmez_pkg;

    // cordic datapath: q2.14 entries scaled by 2^14, plus headroom for gain
    localparam int D_W        = 34;
    // angle accumulator: radians times 2^30
    localparam int Z_W        = 34;
    localparam int GUARD_BITS = 14;
    localparam int ANGLE_W    = 16;
    localparam int ROT_W      = 16;
    localparam int TRANS_W    = 32;
    localparam int GAIN_W     = 32;
    localparam int Q_W        = Z_W - 16;

    localparam int CORDIC_STEPS_DEFAULT = 16;

    localparam int ATAN_DEPTH = 32;
    localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);

    localparam logic signed [Z_W-1:0] HALF_PI     = Z_W'(1686629713);
    localparam logic [GAIN_W-1:0]     INV_GAIN    = 32'd2608131496;
    localparam logic signed [Z_W:0]   ANGLE_ROUND = (Z_W+1)'(65536);
    localparam logic signed [Q_W-1:0] ANGLE_HI    = Q_W'(25736);
    localparam logic signed [Q_W-1:0] ANGLE_LO    = -ANGLE_HI;

    // atan(2^-i) * 2^30, truncated toward zero
    localparam logic [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
        32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
        32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
        32'd262143,    32'd131071,    32'd65535,     32'd32767,
        32'd16383,     32'd8191,      32'd4095,      32'd2047,
        32'd1023,      32'd511,       32'd255,       32'd127,
        32'd63,        32'd31,        32'd15,        32'd7,
        32'd3,         32'd1,         32'd0,         32'd0
    };

    // sideband through the roll pass
    typedef struct packed {
        logic signed [ROT_W-1:0]   rot_00;
        logic signed [ROT_W-1:0]   rot_10;
        logic signed [ROT_W-1:0]   rot_20;
        logic signed [TRANS_W-1:0] trans_x;
        logic signed [TRANS_W-1:0] trans_y;
        logic signed [TRANS_W-1:0] trans_z;
    } side1_t;

    // sideband through the pitch and yaw pass
    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [TRANS_W-1:0] trans_x;
        logic signed [TRANS_W-1:0] trans_y;
        logic signed [TRANS_W-1:0] trans_z;
    } side2_t;

    function automatic logic signed [D_W-1:0] scale_entry(input logic signed [ROT_W-1:0] v);
        logic signed [D_W-1:0] ext;
        ext = D_W'(v);
        return ext <<< GUARD_BITS;
    endfunction

    // round half up to q3.13 and clamp to +-pi
    function automatic logic signed [ANGLE_W-1:0] angle_out(input logic signed [Z_W-1:0] z);
        logic signed [Z_W:0]   sum;
        logic signed [Q_W-1:0] q;
        sum = $signed({z[Z_W-1], z}) + ANGLE_ROUND;
        q   = $signed(sum[Z_W:17]);
        if (q > ANGLE_HI)
        begin
            q = ANGLE_HI;
        end
        else if (q < ANGLE_LO)
        begin
            q = ANGLE_LO;
        end
        return q[ANGLE_W-1:0];
    endfunction

endpackage

// File: rtl/rmez_cordic_pipe.sv
// ----------------------------------------------------------------------------
// rmez_cordic_pipe
// Vectoring cordic, one micro-rotation per register stage, several lanes
// side by side with a sideband word; per-stage valid with bubble collapse.
// ----------------------------------------------------------------------------
module rmez_cordic_pipe #(
    parameter int STEPS  = rmez_pkg::CORDIC_STEPS_DEFAULT,
    parameter int LANES  = 1,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [rmez_pkg::D_W-1:0]  in_x [LANES],
    input  logic signed [rmez_pkg::D_W-1:0]  in_y [LANES],
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [rmez_pkg::Z_W-1:0]  out_z [LANES],
    output logic signed [rmez_pkg::D_W-1:0]  out_mag [LANES],
    output logic [SIDE_W-1:0]                out_side
);

    logic [STEPS:0]   valid_reg;
    logic [STEPS+1:0] ready;

    logic signed [rmez_pkg::D_W-1:0] x_reg  [STEPS+1][LANES];
    logic signed [rmez_pkg::D_W-1:0] y_reg  [STEPS+1][LANES];
    logic signed [rmez_pkg::Z_W-1:0] z_reg  [STEPS+1][LANES];
    logic signed [rmez_pkg::D_W-1:0] x_next [STEPS+1][LANES];
    logic signed [rmez_pkg::D_W-1:0] y_next [STEPS+1][LANES];
    logic signed [rmez_pkg::Z_W-1:0] z_next [STEPS+1][LANES];
    logic [LANES-1:0]                zero_reg  [STEPS+1];
    logic [LANES-1:0]                zero_next;
    logic [SIDE_W-1:0]               side_reg  [STEPS+1];

    // a stage can load when it is empty or its successor moves
    assign ready[STEPS+1] = out_ready;
    for (genvar s = 0; s <= STEPS; s++)
    begin : g_ready
        assign ready[s] = !valid_reg[s] || ready[s+1];
    end
    assign in_ready = ready[0];

    always_comb
    begin
        logic signed [rmez_pkg::D_W-1:0] dx;
        logic signed [rmez_pkg::D_W-1:0] dy;
        logic signed [rmez_pkg::Z_W-1:0] a;
        dx = '0;
        dy = '0;
        a  = '0;
        // pre-rotation into the right half plane
        for (int l = 0; l < LANES; l++)
        begin
            zero_next[l] = (in_x[l] == '0) && (in_y[l] == '0);
            x_next[0][l] = in_x[l];
            y_next[0][l] = in_y[l];
            z_next[0][l] = '0;
            if (in_x[l] < 0)
            begin
                if (in_y[l] >= 0)
                begin
                    x_next[0][l] = in_y[l];
                    y_next[0][l] = -in_x[l];
                    z_next[0][l] = rmez_pkg::HALF_PI;
                end
                else
                begin
                    x_next[0][l] = -in_y[l];
                    y_next[0][l] = in_x[l];
                    z_next[0][l] = -rmez_pkg::HALF_PI;
                end
            end
        end
        // micro-rotations, each stage reads only its predecessor register
        for (int s = 1; s <= STEPS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dx = y_reg[s-1][l] >>> (s - 1);
                dy = x_reg[s-1][l] >>> (s - 1);
                a  = rmez_pkg::Z_W'(rmez_pkg::ATAN_TABLE[rmez_pkg::ATAN_IDX_W'(s - 1)]);
                if (y_reg[s-1][l] > 0)
                begin
                    x_next[s][l] = x_reg[s-1][l] + dx;
                    y_next[s][l] = y_reg[s-1][l] - dy;
                    z_next[s][l] = z_reg[s-1][l] + a;
                end
                else
                begin
                    x_next[s][l] = x_reg[s-1][l] - dx;
                    y_next[s][l] = y_reg[s-1][l] + dy;
                    z_next[s][l] = z_reg[s-1][l] - a;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s <= STEPS; s++)
            begin
                if (ready[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            side_reg[0] <= in_side;
            zero_reg[0] <= zero_next;
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[0][l] <= x_next[0][l];
                y_reg[0][l] <= y_next[0][l];
                z_reg[0][l] <= z_next[0][l];
            end
        end
        for (int s = 1; s <= STEPS; s++)
        begin
            if (ready[s] && valid_reg[s-1])
            begin
                side_reg[s] <= side_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    x_reg[s][l] <= x_next[s][l];
                    y_reg[s][l] <= y_next[s][l];
                    z_reg[s][l] <= z_next[s][l];
                end
            end
        end
    end

    // a zero vector reports angle and magnitude zero
    assign out_valid = valid_reg[STEPS];
    assign out_side  = side_reg[STEPS];
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_z[l]   = zero_reg[STEPS][l] ? '0 : z_reg[STEPS][l];
        assign out_mag[l] = zero_reg[STEPS][l] ? '0 : x_reg[STEPS][l];
    end

    // back pressure at the input only when every stage is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("input stalled while a pipeline stage is empty");

    // pre-rotation leaves x non-negative
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> !x_reg[0][0][rmez_pkg::D_W-1])
        else $error("pre-rotation left a negative x");

    // a nonzero vector ends with a positive magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !zero_reg[STEPS][0]) |-> (out_mag[0] > 0))
        else $error("cordic magnitude not positive");

endmodule

// File: rtl/rmez_gain_stage.sv
// ----------------------------------------------------------------------------
// rmez_gain_stage
// Removes the cordic gain from the roll magnitude and rounds the roll
// angle; one register stage with its own valid.
// ----------------------------------------------------------------------------
module rmez_gain_stage #(
    parameter int SIDE_W = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rmez_pkg::D_W-1:0]     mag,
    input  logic signed [rmez_pkg::Z_W-1:0]     roll_z,
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [rmez_pkg::GAIN_W-1:0]         norm,
    output logic signed [rmez_pkg::ANGLE_W-1:0] roll_angle,
    output logic [SIDE_W-1:0]                   out_side
);

    logic                                valid_reg;
    logic [rmez_pkg::GAIN_W-1:0]         norm_reg;
    logic [rmez_pkg::GAIN_W-1:0]         norm_next;
    logic signed [rmez_pkg::ANGLE_W-1:0] roll_reg;
    logic [SIDE_W-1:0]                   side_reg;
    logic [rmez_pkg::GAIN_W-1:0]         mag_pos;
    logic [2*rmez_pkg::GAIN_W-1:0]       product;

    assign in_ready = !valid_reg || out_ready;

    // magnitude stays below 2^31, negative is clamped to zero
    always_comb
    begin
        mag_pos   = (mag > 0) ? mag[rmez_pkg::GAIN_W-1:0] : '0;
        product   = {{rmez_pkg::GAIN_W{1'b0}}, mag_pos}
                  * {{rmez_pkg::GAIN_W{1'b0}}, rmez_pkg::INV_GAIN};
        norm_next = product[2*rmez_pkg::GAIN_W-1:rmez_pkg::GAIN_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            norm_reg <= norm_next;
            roll_reg <= rmez_pkg::angle_out(roll_z);
            side_reg <= in_side;
        end
    end

    assign out_valid  = valid_reg;
    assign norm       = norm_reg;
    assign roll_angle = roll_reg;
    assign out_side   = side_reg;

endmodule

// File: rtl/rotation_matrix_to_euler_zyx_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx_top
// Pose from a homogeneous transform: translation plus zyx roll, pitch, yaw.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries five rotation entries in
// q2.14 and three translations in q16.16; a transaction completes when
// in_valid is high and in_stall is low. Output channel (out_valid /
// out_stall) returns pos_x/y/z unchanged and roll, pitch, yaw in q3.13
// radians, one result per input, in order.
// Roll is vectored first; the roll magnitude, gain corrected by one 32x32
// multiply, feeds the pitch pass, which runs alongside the yaw pass on
// yaw operands carried along with the roll pass.
// The stages are one pre-rotation stage and CORDIC_STEPS micro-rotation
// stages per pass, the gain stage, and the output register. Throughput is
// one transaction per cycle while out_stall stays low, set by the
// one-stage-per-micro-rotation pipeline.
// Reset clears all valid bits; no item is in flight afterwards.
// When out_stall is high the result holds; stages behind it keep filling
// empty slots, and in_stall rises only once every stage holds an item.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyx_top #(
    parameter int CORDIC_STEPS = rmez_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [rmez_pkg::ROT_W-1:0]   rot_00,
    input  logic signed [rmez_pkg::ROT_W-1:0]   rot_10,
    input  logic signed [rmez_pkg::ROT_W-1:0]   rot_20,
    input  logic signed [rmez_pkg::ROT_W-1:0]   rot_21,
    input  logic signed [rmez_pkg::ROT_W-1:0]   rot_22,
    input  logic signed [rmez_pkg::TRANS_W-1:0] trans_x,
    input  logic signed [rmez_pkg::TRANS_W-1:0] trans_y,
    input  logic signed [rmez_pkg::TRANS_W-1:0] trans_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [rmez_pkg::TRANS_W-1:0] pos_x,
    output logic signed [rmez_pkg::TRANS_W-1:0] pos_y,
    output logic signed [rmez_pkg::TRANS_W-1:0] pos_z,
    output logic signed [rmez_pkg::ANGLE_W-1:0] roll_angle,
    output logic signed [rmez_pkg::ANGLE_W-1:0] pitch_angle,
    output logic signed [rmez_pkg::ANGLE_W-1:0] yaw_angle
);

    localparam int SIDE1_W = $bits(rmez_pkg::side1_t);
    localparam int SIDE2_W = $bits(rmez_pkg::side2_t);

    // roll pass
    logic                            p1_in_ready;
    logic signed [rmez_pkg::D_W-1:0] p1_x [1];
    logic signed [rmez_pkg::D_W-1:0] p1_y [1];
    rmez_pkg::side1_t                p1_side_in;
    logic                            p1_out_valid;
    logic                            p1_out_ready;
    logic signed [rmez_pkg::Z_W-1:0] p1_z [1];
    logic signed [rmez_pkg::D_W-1:0] p1_mag [1];
    logic [SIDE1_W-1:0]              p1_side_out;

    // gain stage
    logic                                g_out_valid;
    logic                                g_out_ready;
    logic [rmez_pkg::GAIN_W-1:0]         g_norm;
    logic signed [rmez_pkg::ANGLE_W-1:0] g_roll;
    logic [SIDE1_W-1:0]                  g_side_out;
    rmez_pkg::side1_t                    g_side;

    // pitch and yaw pass
    logic signed [rmez_pkg::D_W-1:0] p2_x [2];
    logic signed [rmez_pkg::D_W-1:0] p2_y [2];
    rmez_pkg::side2_t                p2_side_in;
    logic                            p2_out_valid;
    logic                            p2_out_ready;
    logic signed [rmez_pkg::Z_W-1:0] p2_z [2];
    logic [SIDE2_W-1:0]              p2_side_out;
    rmez_pkg::side2_t                p2_side;

    // output register
    logic                                out_valid_reg;
    logic signed [rmez_pkg::TRANS_W-1:0] pos_x_reg;
    logic signed [rmez_pkg::TRANS_W-1:0] pos_y_reg;
    logic signed [rmez_pkg::TRANS_W-1:0] pos_z_reg;
    logic signed [rmez_pkg::ANGLE_W-1:0] roll_reg;
    logic signed [rmez_pkg::ANGLE_W-1:0] pitch_reg;
    logic signed [rmez_pkg::ANGLE_W-1:0] yaw_reg;

    assign p1_x[0] = rmez_pkg::scale_entry(rot_22);
    assign p1_y[0] = rmez_pkg::scale_entry(rot_21);
    assign p1_side_in.rot_00  = rot_00;
    assign p1_side_in.rot_10  = rot_10;
    assign p1_side_in.rot_20  = rot_20;
    assign p1_side_in.trans_x = trans_x;
    assign p1_side_in.trans_y = trans_y;
    assign p1_side_in.trans_z = trans_z;

    rmez_cordic_pipe #(
        .STEPS  (CORDIC_STEPS),
        .LANES  (1),
        .SIDE_W (SIDE1_W)
    ) u_roll_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (p1_in_ready),
        .in_x      (p1_x),
        .in_y      (p1_y),
        .in_side   (p1_side_in),
        .out_valid (p1_out_valid),
        .out_ready (p1_out_ready),
        .out_z     (p1_z),
        .out_mag   (p1_mag),
        .out_side  (p1_side_out)
    );

    assign in_stall = !p1_in_ready;

    rmez_gain_stage #(
        .SIDE_W (SIDE1_W)
    ) u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (p1_out_valid),
        .in_ready   (p1_out_ready),
        .mag        (p1_mag[0]),
        .roll_z     (p1_z[0]),
        .in_side    (p1_side_out),
        .out_valid  (g_out_valid),
        .out_ready  (g_out_ready),
        .norm       (g_norm),
        .roll_angle (g_roll),
        .out_side   (g_side_out)
    );

    assign g_side = rmez_pkg::side1_t'(g_side_out);

    // lane 0 pitch, lane 1 yaw
    assign p2_x[0] = rmez_pkg::D_W'($signed({1'b0, g_norm}));
    assign p2_y[0] = -rmez_pkg::scale_entry(g_side.rot_20);
    assign p2_x[1] = rmez_pkg::scale_entry(g_side.rot_00);
    assign p2_y[1] = rmez_pkg::scale_entry(g_side.rot_10);
    assign p2_side_in.roll_angle = g_roll;
    assign p2_side_in.trans_x    = g_side.trans_x;
    assign p2_side_in.trans_y    = g_side.trans_y;
    assign p2_side_in.trans_z    = g_side.trans_z;

    rmez_cordic_pipe #(
        .STEPS  (CORDIC_STEPS),
        .LANES  (2),
        .SIDE_W (SIDE2_W)
    ) u_pitch_yaw_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (g_out_valid),
        .in_ready  (g_out_ready),
        .in_x      (p2_x),
        .in_y      (p2_y),
        .in_side   (p2_side_in),
        .out_valid (p2_out_valid),
        .out_ready (p2_out_ready),
        .out_z     (p2_z),
        .out_mag   (),
        .out_side  (p2_side_out)
    );

    assign p2_side      = rmez_pkg::side2_t'(p2_side_out);
    assign p2_out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (p2_out_ready)
        begin
            out_valid_reg <= p2_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p2_out_ready && p2_out_valid)
        begin
            pos_x_reg <= p2_side.trans_x;
            pos_y_reg <= p2_side.trans_y;
            pos_z_reg <= p2_side.trans_z;
            roll_reg  <= p2_side.roll_angle;
            pitch_reg <= rmez_pkg::angle_out(p2_z[0]);
            yaw_reg   <= rmez_pkg::angle_out(p2_z[1]);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = pos_x_reg;
    assign pos_y       = pos_y_reg;
    assign pos_z       = pos_z_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

endmodule

// File: dv/pose_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pose_check_pkg
// Transaction types, a bit-exact pose predictor and the in-order result
// scoreboard for the rotation matrix to zyx euler angle testbench.
// ----------------------------------------------------------------------------
package pose_check_pkg;

    localparam int PASS_STEPS = rmez_pkg::CORDIC_STEPS_DEFAULT;

    localparam longint          HALF_PI_Q30  = 64'sd1686629713;
    localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;
    localparam longint          ANGLE_CLAMP  = 64'sd25736;
    localparam int              OPERAND_SHIFT = 14;

    // atan(2^-i) in radians * 2^30, truncated
    localparam longint ATAN_Q30 [32] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767,
        16383,     8191,      4095,      2047,
        1023,      511,       255,       127,
        63,        31,        15,        7,
        3,         1,         0,         0
    };

    typedef struct packed {
        logic signed [rmez_pkg::ROT_W-1:0]   rot_00;
        logic signed [rmez_pkg::ROT_W-1:0]   rot_10;
        logic signed [rmez_pkg::ROT_W-1:0]   rot_20;
        logic signed [rmez_pkg::ROT_W-1:0]   rot_21;
        logic signed [rmez_pkg::ROT_W-1:0]   rot_22;
        logic signed [rmez_pkg::TRANS_W-1:0] trans_x;
        logic signed [rmez_pkg::TRANS_W-1:0] trans_y;
        logic signed [rmez_pkg::TRANS_W-1:0] trans_z;
    } transform_t;

    typedef struct packed {
        logic signed [rmez_pkg::TRANS_W-1:0] pos_x;
        logic signed [rmez_pkg::TRANS_W-1:0] pos_y;
        logic signed [rmez_pkg::TRANS_W-1:0] pos_z;
        logic signed [rmez_pkg::ANGLE_W-1:0] roll_angle;
        logic signed [rmez_pkg::ANGLE_W-1:0] pitch_angle;
        logic signed [rmez_pkg::ANGLE_W-1:0] yaw_angle;
    } pose_t;

    class pose_scoreboard;
        pose_t       pending_poses[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        // vectoring pass, angle in radians * 2^30, mag is the final x with gain
        function longint vector_angle(input longint y_in, input longint x_in,
                                      output longint mag);
            longint x;
            longint y;
            longint z;
            longint t;
            longint dx;
            longint dy;
            longint a;
            int     sh;
            x = x_in;
            y = y_in;
            z = 0;
            if (x == 0 && y == 0)
            begin
                mag = 0;
                return 0;
            end
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = HALF_PI_Q30;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -HALF_PI_Q30;
                end
            end
            for (int i = 0; i < PASS_STEPS; i++)
            begin
                sh = (i > 63) ? 63 : i;
                dx = y >>> sh;
                dy = x >>> sh;
                a  = (i < 32) ? ATAN_Q30[i] : 0;
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + a;
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - a;
                end
            end
            mag = x;
            return z;
        endfunction

        // round half up to q3.13, clamp to +-pi
        function logic signed [rmez_pkg::ANGLE_W-1:0] quantize_angle(input longint z);
            longint q;
            q = (z + 64'sd65536) >>> 17;
            if (q > ANGLE_CLAMP)
            begin
                q = ANGLE_CLAMP;
            end
            if (q < -ANGLE_CLAMP)
            begin
                q = -ANGLE_CLAMP;
            end
            return q[rmez_pkg::ANGLE_W-1:0];
        endfunction

        function pose_t predict_pose(input transform_t t);
            longint          r00;
            longint          r10;
            longint          r20;
            longint          r21;
            longint          r22;
            longint          mag;
            longint          spare;
            longint          norm;
            longint          roll;
            longint          pitch;
            longint          yaw;
            longint unsigned m;
            pose_t           p;
            r00 = longint'(t.rot_00) <<< OPERAND_SHIFT;
            r10 = longint'(t.rot_10) <<< OPERAND_SHIFT;
            r20 = longint'(t.rot_20) <<< OPERAND_SHIFT;
            r21 = longint'(t.rot_21) <<< OPERAND_SHIFT;
            r22 = longint'(t.rot_22) <<< OPERAND_SHIFT;
            roll  = vector_angle(r21, r22, mag);
            m     = (mag > 0) ? $unsigned(mag) : 64'd0;
            norm  = $signed((m * INV_GAIN_Q32) >> 32);
            pitch = vector_angle(-r20, norm, spare);
            yaw   = vector_angle(r10, r00, spare);
            p.pos_x       = t.trans_x;
            p.pos_y       = t.trans_y;
            p.pos_z       = t.trans_z;
            p.roll_angle  = quantize_angle(roll);
            p.pitch_angle = quantize_angle(pitch);
            p.yaw_angle   = quantize_angle(yaw);
            return p;
        endfunction

        function void note_transform(input transform_t t);
            pending_poses.push_back(predict_pose(t));
        endfunction

        function void compare_field(input string name, input longint want,
                                    input longint got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_pose(input pose_t got);
            pose_t want;
            if (pending_poses.size() == 0)
            begin
                $display("%0t: pose with no transaction pending, actual roll %0d pitch %0d yaw %0d",
                         $time, got.roll_angle, got.pitch_angle, got.yaw_angle);
                errors++;
                return;
            end
            want = pending_poses.pop_front();
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("pos_z", want.pos_z, got.pos_z);
            compare_field("roll_angle", want.roll_angle, got.roll_angle);
            compare_field("pitch_angle", want.pitch_angle, got.pitch_angle);
            compare_field("yaw_angle", want.yaw_angle, got.yaw_angle);
        endfunction

        function int outstanding();
            return pending_poses.size();
        endfunction
    endclass

endpackage

// File: dv/rotation_matrix_to_euler_zyx_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_zyx_top_test
// Drives transforms into the pose pipeline, directed corners first and then
// random entries, under phases of sender gaps and receiver stalls, and
// checks every pose in order against a bit-exact predictor.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_zyx_top_test;

    localparam int RANDOM_PER_PHASE = 400;
    localparam int DRAIN_CYCLES     = 2 * pose_check_pkg::PASS_STEPS + 4 + 16;
    localparam int WATCHDOG_LIMIT   = 4000;

    localparam logic signed [15:0] CORNER_ENTRIES [8] = '{
        16'sd0, 16'sd1, -16'sd1, 16'sd16384, -16'sd16384, 16'sd32767, -16'sd32768, 16'sd11585
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic signed [rmez_pkg::ROT_W-1:0]   rot_00;
    logic signed [rmez_pkg::ROT_W-1:0]   rot_10;
    logic signed [rmez_pkg::ROT_W-1:0]   rot_20;
    logic signed [rmez_pkg::ROT_W-1:0]   rot_21;
    logic signed [rmez_pkg::ROT_W-1:0]   rot_22;
    logic signed [rmez_pkg::TRANS_W-1:0] trans_x;
    logic signed [rmez_pkg::TRANS_W-1:0] trans_y;
    logic signed [rmez_pkg::TRANS_W-1:0] trans_z;
    logic        out_valid;
    logic        out_stall;
    logic signed [rmez_pkg::TRANS_W-1:0] pos_x;
    logic signed [rmez_pkg::TRANS_W-1:0] pos_y;
    logic signed [rmez_pkg::TRANS_W-1:0] pos_z;
    logic signed [rmez_pkg::ANGLE_W-1:0] roll_angle;
    logic signed [rmez_pkg::ANGLE_W-1:0] pitch_angle;
    logic signed [rmez_pkg::ANGLE_W-1:0] yaw_angle;

    pose_check_pkg::pose_scoreboard pose_sb;
    int unsigned    send_idle_pct;
    int unsigned    stall_pct;
    int unsigned    quiet_cycles;

    rotation_matrix_to_euler_zyx_top #(
        .CORDIC_STEPS(pose_check_pkg::PASS_STEPS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rot_00(rot_00),
        .rot_10(rot_10),
        .rot_20(rot_20),
        .rot_21(rot_21),
        .rot_22(rot_22),
        .trans_x(trans_x),
        .trans_y(trans_y),
        .trans_z(trans_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .pos_z(pos_z),
        .roll_angle(roll_angle),
        .pitch_angle(pitch_angle),
        .yaw_angle(yaw_angle)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // presents one transform and holds it until the transaction completes
    task automatic send_transform(input pose_check_pkg::transform_t t);
        int unsigned gap;
        in_valid <= 1'b1;
        rot_00   <= t.rot_00;
        rot_10   <= t.rot_10;
        rot_20   <= t.rot_20;
        rot_21   <= t.rot_21;
        rot_22   <= t.rot_22;
        trans_x  <= t.trans_x;
        trans_y  <= t.trans_y;
        trans_z  <= t.trans_z;
        do
            @(posedge clk);
        while (in_stall);
        pose_sb.note_transform(t);
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_rotation(input int r00, input int r10, input int r20,
                                 input int r21, input int r22);
        pose_check_pkg::transform_t t;
        t.rot_00  = r00[15:0];
        t.rot_10  = r10[15:0];
        t.rot_20  = r20[15:0];
        t.rot_21  = r21[15:0];
        t.rot_22  = r22[15:0];
        t.trans_x = $urandom;
        t.trans_y = $urandom;
        t.trans_z = $urandom;
        send_transform(t);
    endtask

    // hold the input side idle until every pose has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pose_sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic signed [15:0] pick_entry(input int unsigned flavor);
        case (flavor)
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(32768)) - 16384);
            2: return CORNER_ENTRIES[$urandom_range(7)];
            default: return 16'(int'($urandom_range(16)) - 8);
        endcase
    endfunction

    task automatic send_random();
        pose_check_pkg::transform_t t;
        int unsigned mix;
        mix = $urandom_range(99);
        if (mix < 35)
        begin
            t.rot_00 = pick_entry(0);
            t.rot_10 = pick_entry(0);
            t.rot_20 = pick_entry(0);
            t.rot_21 = pick_entry(0);
            t.rot_22 = pick_entry(0);
        end
        else if (mix < 65)
        begin
            t.rot_00 = pick_entry(1);
            t.rot_10 = pick_entry(1);
            t.rot_20 = pick_entry(1);
            t.rot_21 = pick_entry(1);
            t.rot_22 = pick_entry(1);
        end
        else
        begin
            // corners, near-zero operands and gimbal-lock neighbors
            t.rot_00 = pick_entry($urandom_range(1, 3));
            t.rot_10 = pick_entry($urandom_range(1, 3));
            t.rot_20 = pick_entry($urandom_range(1, 3));
            t.rot_21 = pick_entry($urandom_range(2, 3));
            t.rot_22 = pick_entry($urandom_range(2, 3));
        end
        t.trans_x = $urandom;
        t.trans_y = $urandom;
        t.trans_z = $urandom;
        send_transform(t);
    endtask

    // receiver: check completed transactions, then pick the next stall
    always @(posedge clk)
    begin : rx_side
        pose_check_pkg::pose_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.pos_x       = pos_x;
            got.pos_y       = pos_y;
            got.pos_z       = pos_z;
            got.roll_angle  = roll_angle;
            got.pitch_angle = pitch_angle;
            got.yaw_angle   = yaw_angle;
            pose_sb.check_pose(got);
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin : watchdog
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        pose_check_pkg::transform_t t;
        int unsigned idle_phase [4];
        int unsigned stall_phase [4];
        idle_phase  = '{0, 60, 0, 11};
        stall_phase = '{0, 0, 60, 11};
        pose_sb       = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        rot_00    <= '0;
        rot_10    <= '0;
        rot_20    <= '0;
        rot_21    <= '0;
        rot_22    <= '0;
        trans_x   <= '0;
        trans_y   <= '0;
        trans_z   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // translation extremes with an identity rotation
        t = '{16384, 0, 0, 0, 16384, 32'sh7fffffff, 32'sh80000000, 32'sh0};
        send_transform(t);
        t = '{16384, 0, 0, 0, 16384, 32'sh80000000, 32'sh0, 32'sh7fffffff};
        send_transform(t);
        t = '{16384, 0, 0, 0, 16384, -32'sd1, 32'sh55555555, 32'shaaaaaaaa};
        send_transform(t);
        // all zero: both operands zero everywhere
        send_rotation(0, 0, 0, 0, 0);
        // entry extremes
        send_rotation(32767, 32767, 32767, 32767, 32767);
        send_rotation(-32768, -32768, -32768, -32768, -32768);
        send_rotation(32767, -32768, 32767, -32768, 32767);
        send_rotation(-32768, 32767, -32768, 32767, -32768);
        // zero roll operands, pitch at +-pi/2
        send_rotation(0, 0, -16384, 0, 0);
        send_rotation(0, 0, 16384, 0, 0);
        send_rotation(0, 0, -32768, 0, 0);
        // negative x with zero y lands on +pi
        send_rotation(-16384, 0, 0, 0, -16384);
        send_rotation(-32768, 0, 0, 0, -32768);
        send_rotation(-1, 0, 0, 0, -1);
        // negative x with y of either sign
        send_rotation(-16384, 1, 0, -1, -16384);
        send_rotation(-11585, -11585, 0, 11585, -11585);
        // zero x with y of either sign
        send_rotation(0, 16384, 0, -16384, 0);
        send_rotation(0, -16384, 0, 16384, 0);
        // roll, pitch and yaw all at 45 degrees, then all at -45 degrees
        send_rotation(11585, 11585, -11585, 8192, 8192);
        send_rotation(11585, -11585, 11585, -8192, 8192);
        // smallest nonzero operands
        send_rotation(1, -1, 1, 1, -1);
        // not a rotation at all
        send_rotation(30000, -2, 12345, -32000, 7);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_phase[ph];
            stall_pct     = stall_phase[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                send_random();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pose_sb.errors == 0 && pose_sb.outstanding() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: rotation_matrix_to_euler_zyx_top.f
rtl/rmez_pkg.sv
rtl/rmez_cordic_pipe.sv
rtl/rmez_gain_stage.sv
rtl/rotation_matrix_to_euler_zyx_top.sv
dv/pose_check_pkg.sv
dv/rotation_matrix_to_euler_zyx_top_test.sv
